[rtl/pds_pkg.sv]
// pds_pkg: shared constants and types of the pid drive with slew and settle block
// register indexes, reset values, widths and the item action codes
// no dependencies
`timescale 1ns / 1ps

package pds_pkg;

    // encoder position width: default and largest supported value
    localparam int POS_WIDTH_DEF = 24;
    localparam int POS_WIDTH_MAX = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register widths
    localparam int GAIN_W   = 32;
    localparam int ICAP_W   = 24;
    localparam int SLEW_W   = 7;
    localparam int SETTLE_W = 16;

    // register reset values
    localparam logic [GAIN_W-1:0]   KP_RESET     = 32'd1342177;
    localparam logic [GAIN_W-1:0]   KI_RESET     = 32'd168;
    localparam logic [GAIN_W-1:0]   KD_RESET     = 32'd335544;
    localparam logic [ICAP_W-1:0]   ICAP_RESET   = 24'd90000;
    localparam logic [SLEW_W-1:0]   SLEW_RESET   = 7'd3;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd85;

    // speed cap start value and ceiling, drive floor
    localparam logic [SLEW_W-1:0] SPEED_START = 7'd5;
    localparam logic [SLEW_W-1:0] SPEED_MAX   = 7'd100;
    localparam int                DRIVE_MIN   = -100;

    // field widths
    localparam int TARGET_W = 16;
    localparam int DRIVE_W  = 8;
    localparam int ERR_W    = 32;
    localparam int SUM_W    = 40;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN      = 3'd0,
        CFG_KI_GAIN      = 3'd1,
        CFG_KD_GAIN      = 3'd2,
        CFG_INTEGRAL_CAP = 3'd3,
        CFG_SLEW_STEP    = 3'd4,
        CFG_SETTLE_TICKS = 3'd5
    } t_cfg_idx;

    // item action codes
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } t_action;

endpackage

[rtl/pds_ifs.sv]
// pds_ifs: valid/ready channel interfaces of the pid drive block
// command channel (start or tick word) and result channel (drive word)
// depends on pds_pkg
`timescale 1ns / 1ps

interface pds_cmd_if #(
    parameter int POS_WIDTH = pds_pkg::POS_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [pds_pkg::TARGET_W-1:0] target;
    logic signed [POS_WIDTH-1:0]         left_pos;
    logic signed [POS_WIDTH-1:0]         right_pos;

    modport source (output valid, action, target, left_pos, right_pos, input ready);
    modport sink   (input valid, action, target, left_pos, right_pos, output ready);
endinterface

interface pds_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [pds_pkg::DRIVE_W-1:0] drive_pct;
    logic                               done_res;

    modport source (output valid, drive_pct, done_res, input ready);
    modport sink   (input valid, drive_pct, done_res, output ready);
endinterface

[rtl/pid_drive_with_slew_and_settle.sv]
// pid_drive_with_slew_and_settle: pid drive with integral clamp, slew limit and settle timer
// five-register pipeline: input, state update, partial products, partial sums, result
// depends on pds_pkg and the channel interfaces in pds_ifs
//
//   channel   dir  modport  words
//   i_cmd     in   sink     action, target, left_pos, right_pos
//   o_res     out  source   drive_pct, done_res
//   i_cfg_*   in   write    index 0..5 (kp, ki, kd, integral cap, slew step, settle ticks)
//
// one word accepted per cycle while a stalled o_res does not hold the full pipeline
// the loop-carried state (error, derivative, sum, speed cap, settle timer) updates in
// the single state stage, the three gain multiplies run later as 16-bit-half products
// each stage moves up when the next one is empty or moving, so words keep entering
// while a result waits on o_res, until the pipeline is full
// reset is synchronous, active low; it clears valid bits, state and configuration registers
`timescale 1ns / 1ps

module pid_drive_with_slew_and_settle #(
    parameter int POS_WIDTH = pds_pkg::POS_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pds_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pds_cmd_if.sink                          i_cmd,
    pds_res_if.source                        o_res
);
    import pds_pkg::*;

    // internal widths
    localparam int EXT_W  = POS_WIDTH_MAX + 2;      // position difference and error
    localparam int HALF_W = GAIN_W / 2;             // gain half
    localparam int PE_W   = ERR_W + HALF_W + 1;     // error or derivative times a half
    localparam int PS_W   = SUM_W + HALF_W + 1;     // sum times a half
    localparam int ACC_W  = PS_W + 2;               // sum of three products
    localparam int TOT_W  = ACC_W + HALF_W;         // full weighted sum
    localparam int FRAC_W = 25;                     // q8.24 point and half-degree unit
    localparam int Q_W    = TOT_W - FRAC_W;

    localparam logic signed [EXT_W-1:0]  E_MAX = EXT_W'(64'sd2147483647);
    localparam logic signed [EXT_W-1:0]  E_MIN = -EXT_W'(64'sd2147483648);
    localparam logic [SETTLE_W-1:0]      CNT_MAX = {SETTLE_W{1'b1}};

    // configuration registers
    logic [GAIN_W-1:0]   r_kp_gain;
    logic [GAIN_W-1:0]   r_ki_gain;
    logic [GAIN_W-1:0]   r_kd_gain;
    logic [ICAP_W-1:0]   r_integral_cap;
    logic [SLEW_W-1:0]   r_slew_step;
    logic [SETTLE_W-1:0] r_settle_ticks;

    // loop state
    logic signed [TARGET_W-1:0] r_goal;
    logic signed [ERR_W-1:0]    r_last_error;
    logic signed [ERR_W-1:0]    r_last_deriv;
    logic signed [SUM_W-1:0]    r_error_sum;
    logic [SLEW_W-1:0]          r_speed_cap;
    logic                       r_moving;
    logic [SETTLE_W-1:0]        r_settle_count;

    // input stage
    logic                        r_i_valid;
    logic                        r_i_action;
    logic signed [TARGET_W-1:0]  r_i_target;
    logic signed [POS_WIDTH-1:0] r_i_left;
    logic signed [POS_WIDTH-1:0] r_i_right;

    // state stage
    logic                     r_a_valid;
    logic                     r_a_zero;
    logic                     r_a_done;
    logic [SLEW_W-1:0]        r_a_cap;
    logic signed [ERR_W-1:0]  r_a_e;
    logic signed [ERR_W-1:0]  r_a_d;
    logic signed [SUM_W-1:0]  r_a_s;

    // product stage
    logic                    r_b_valid;
    logic                    r_b_zero;
    logic                    r_b_done;
    logic [SLEW_W-1:0]       r_b_cap;
    logic signed [PE_W-1:0]  r_b_kp_hi;
    logic signed [PE_W-1:0]  r_b_kp_lo;
    logic signed [PS_W-1:0]  r_b_ki_hi;
    logic signed [PS_W-1:0]  r_b_ki_lo;
    logic signed [PE_W-1:0]  r_b_kd_hi;
    logic signed [PE_W-1:0]  r_b_kd_lo;

    // partial sum stage
    logic                     r_c_valid;
    logic                     r_c_zero;
    logic                     r_c_done;
    logic [SLEW_W-1:0]        r_c_cap;
    logic signed [ACC_W-1:0]  r_c_hi;
    logic signed [ACC_W-1:0]  r_c_lo;

    // result stage
    logic                       r_o_valid;
    logic signed [DRIVE_W-1:0]  r_o_drive;
    logic                       r_o_done;

    // stage advance chain
    logic w_adv_o, w_adv_c, w_adv_b, w_adv_a, w_adv_i;

    assign w_adv_o = !r_o_valid || o_res.ready;
    assign w_adv_c = !r_c_valid || w_adv_o;
    assign w_adv_b = !r_b_valid || w_adv_c;
    assign w_adv_a = !r_a_valid || w_adv_b;
    assign w_adv_i = !r_i_valid || w_adv_a;

    assign i_cmd.ready = w_adv_i;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_gain      <= KP_RESET;
            r_ki_gain      <= KI_RESET;
            r_kd_gain      <= KD_RESET;
            r_integral_cap <= ICAP_RESET;
            r_slew_step    <= SLEW_RESET;
            r_settle_ticks <= SETTLE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP_GAIN:      r_kp_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_GAIN:      r_ki_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_GAIN:      r_kd_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_CAP: r_integral_cap <= i_cfg_data[ICAP_W-1:0];
                CFG_SLEW_STEP:    r_slew_step    <= i_cfg_data[SLEW_W-1:0];
                CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (w_adv_i) begin
            r_i_valid <= i_cmd.valid;
        end
        if (w_adv_i) begin
            r_i_action <= i_cmd.action;
            r_i_target <= i_cmd.target;
            r_i_left   <= i_cmd.left_pos;
            r_i_right  <= i_cmd.right_pos;
        end
    end

    // error, derivative and sum with saturation
    logic signed [EXT_W-1:0]   w_pos;
    logic signed [EXT_W-1:0]   w_e_wide;
    logic signed [ERR_W-1:0]   w_e;
    logic signed [ERR_W:0]     w_d_wide;
    logic signed [ERR_W-1:0]   w_d;
    logic signed [SUM_W:0]     w_s_wide;
    logic signed [SUM_W-1:0]   w_s;
    logic signed [SUM_W-1:0]   w_sum_lim;
    logic signed [SUM_W-1:0]   w_s_clamped;
    logic [SLEW_W:0]           w_cap_sum;
    logic [SLEW_W-1:0]         w_cap_next;
    logic [SETTLE_W-1:0]       w_cnt_base;
    logic                      w_is_tick;
    logic                      w_blocked;
    logic                      w_still;

    always_comb begin
        w_pos    = EXT_W'(r_i_right) - EXT_W'(r_i_left);
        w_e_wide = EXT_W'($signed({r_goal, 1'b0})) - w_pos;
        if (w_e_wide > E_MAX) begin
            w_e = ERR_W'(E_MAX);
        end else if (w_e_wide < E_MIN) begin
            w_e = ERR_W'(E_MIN);
        end else begin
            w_e = ERR_W'(w_e_wide);
        end

        w_d_wide = (ERR_W+1)'(w_e) - (ERR_W+1)'(r_last_error);
        if (w_d_wide[ERR_W] != w_d_wide[ERR_W-1]) begin
            w_d = {w_d_wide[ERR_W], {(ERR_W-1){!w_d_wide[ERR_W]}}};
        end else begin
            w_d = w_d_wide[ERR_W-1:0];
        end

        w_s_wide = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(w_e);
        if (w_s_wide[SUM_W] != w_s_wide[SUM_W-1]) begin
            w_s = {w_s_wide[SUM_W], {(SUM_W-1){!w_s_wide[SUM_W]}}};
        end else begin
            w_s = w_s_wide[SUM_W-1:0];
        end

        // stored sum is clamped above at twice the cap (half-degree units)
        w_sum_lim   = $signed({{(SUM_W-ICAP_W-1){1'b0}}, r_integral_cap, 1'b0});
        w_s_clamped = (w_s > w_sum_lim) ? w_sum_lim : w_s;

        w_cap_sum  = (SLEW_W+1)'(r_speed_cap) + (SLEW_W+1)'(r_slew_step);
        w_cap_next = (w_cap_sum > (SLEW_W+1)'(SPEED_MAX)) ? SPEED_MAX
                                                          : w_cap_sum[SLEW_W-1:0];

        w_cnt_base = r_moving ? '0 : r_settle_count;
        w_still    = (r_last_deriv > -ERR_W'(2)) && (r_last_deriv < ERR_W'(2));
        w_is_tick  = (r_i_action == ACT_TICK);
        w_blocked  = (r_settle_count >= r_settle_ticks);
    end

    // state stage: loop state update and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_goal         <= '0;
            r_last_error   <= '0;
            r_last_deriv   <= '0;
            r_error_sum    <= '0;
            r_speed_cap    <= SPEED_START;
            r_moving       <= 1'b1;
            r_settle_count <= '0;
        end else if (w_adv_a) begin
            r_a_valid <= r_i_valid;
            if (r_i_valid) begin
                if (!w_is_tick) begin
                    r_goal         <= r_i_target;
                    r_settle_count <= '0;
                end else if (!w_blocked) begin
                    r_moving       <= !w_still;
                    r_last_error   <= w_e;
                    r_last_deriv   <= w_d;
                    r_error_sum    <= w_s_clamped;
                    r_speed_cap    <= w_cap_next;
                    r_settle_count <= (w_cnt_base < CNT_MAX) ? w_cnt_base + 1'b1
                                                             : w_cnt_base;
                end
            end
        end
        if (w_adv_a) begin
            r_a_zero <= !w_is_tick || w_blocked;
            r_a_done <= w_is_tick && w_blocked;
            r_a_cap  <= w_cap_next;
            r_a_e    <= w_e;
            r_a_d    <= w_d;
            r_a_s    <= w_s;
        end
    end

    // product stage: each gain split into 16-bit halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv_b) begin
            r_b_valid <= r_a_valid;
        end
        if (w_adv_b) begin
            r_b_zero  <= r_a_zero;
            r_b_done  <= r_a_done;
            r_b_cap   <= r_a_cap;
            r_b_kp_hi <= PE_W'(r_a_e) * PE_W'($signed({1'b0, r_kp_gain[GAIN_W-1:HALF_W]}));
            r_b_kp_lo <= PE_W'(r_a_e) * PE_W'($signed({1'b0, r_kp_gain[HALF_W-1:0]}));
            r_b_ki_hi <= PS_W'(r_a_s) * PS_W'($signed({1'b0, r_ki_gain[GAIN_W-1:HALF_W]}));
            r_b_ki_lo <= PS_W'(r_a_s) * PS_W'($signed({1'b0, r_ki_gain[HALF_W-1:0]}));
            r_b_kd_hi <= PE_W'(r_a_d) * PE_W'($signed({1'b0, r_kd_gain[GAIN_W-1:HALF_W]}));
            r_b_kd_lo <= PE_W'(r_a_d) * PE_W'($signed({1'b0, r_kd_gain[HALF_W-1:0]}));
        end
    end

    // partial sum stage: high halves and low halves added apart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv_c) begin
            r_c_valid <= r_b_valid;
        end
        if (w_adv_c) begin
            r_c_zero <= r_b_zero;
            r_c_done <= r_b_done;
            r_c_cap  <= r_b_cap;
            r_c_hi   <= ACC_W'(r_b_kp_hi) + ACC_W'(r_b_ki_hi) + ACC_W'(r_b_kd_hi);
            r_c_lo   <= ACC_W'(r_b_kp_lo) + ACC_W'(r_b_ki_lo) + ACC_W'(r_b_kd_lo);
        end
    end

    // full sum, floor shift and drive limits; start and done words get a zero drive
    logic signed [TOT_W-1:0]   w_total;
    logic signed [Q_W-1:0]     w_q;
    logic signed [Q_W-1:0]     w_q_cap;
    logic signed [DRIVE_W-1:0] w_drive;

    always_comb begin
        w_total = (TOT_W'(r_c_hi) <<< HALF_W) + TOT_W'(r_c_lo);
        w_q     = $signed(w_total[TOT_W-1:FRAC_W]);
        w_q_cap = $signed(Q_W'({1'b0, r_c_cap}));
        if (r_c_zero) begin
            w_drive = '0;
        end else if (w_q > w_q_cap) begin
            w_drive = $signed({1'b0, r_c_cap});
        end else if (w_q < Q_W'(DRIVE_MIN)) begin
            w_drive = DRIVE_W'(DRIVE_MIN);
        end else begin
            w_drive = w_q[DRIVE_W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv_o) begin
            r_o_valid <= r_c_valid;
        end
        if (w_adv_o) begin
            r_o_drive <= w_drive;
            r_o_done  <= r_c_done;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.drive_pct = r_o_drive;
    assign o_res.done_res  = r_o_done;

    // done words always carry a stopped drive
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_done |-> r_o_drive == '0)
        else $error("done result with nonzero drive");

    // drive stays inside the motor range
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_drive <= $signed(DRIVE_W'(SPEED_MAX)))
                      && (r_o_drive >= DRIVE_W'(DRIVE_MIN)))
        else $error("drive out of range");

    // speed cap never grows past its ceiling
    a_cap_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed_cap <= SPEED_MAX && r_a_cap <= SPEED_MAX)
        else $error("speed cap above ceiling");

    // an empty input stage always takes a word
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_i_valid |-> i_cmd.ready)
        else $error("empty input stage stalled");

    // a start word clears the settle timer
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv_a && r_i_valid && !w_is_tick |=> r_settle_count == '0)
        else $error("start did not clear settle timer");

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for the pid drive with slew limit and settle timer
// drives command words with random gaps, predicts each drive word and checks the result
// depends on pds_pkg, the channel interfaces in pds_ifs and pid_drive_with_slew_and_settle
`timescale 1ns / 1ps

module testbench;
    import pds_pkg::*;

    localparam int POS_WIDTH   = POS_WIDTH_DEF;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_PAUSE = 8;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_WORDS = 82;

    // unused register slots, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [63:0] ERR_MIN = -(64'sd1 <<< (ERR_W - 1));
    localparam logic signed [63:0] ERR_MAX = (64'sd1 <<< (ERR_W - 1)) - 1;
    localparam logic signed [63:0] SUM_MIN = -(64'sd1 <<< (SUM_W - 1));
    localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 1;

    typedef struct {
        t_action                     action;
        logic signed [TARGET_W-1:0]  target;
        logic signed [POS_WIDTH-1:0] left_pos;
        logic signed [POS_WIDTH-1:0] right_pos;
    } cmd_word_t;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive_pct;
        logic                      done_res;
    } drive_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pds_cmd_if #(.POS_WIDTH(POS_WIDTH)) cmd_bus ();
    pds_res_if                          res_bus ();

    pid_drive_with_slew_and_settle #(.POS_WIDTH(POS_WIDTH)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_bus.sink),
        .o_res      (res_bus.source)
    );

    always #5 i_clk = ~i_clk;

    // pending command words and expected drive words
    cmd_word_t   cmd_backlog[$];
    drive_word_t drive_expected[$];
    cmd_word_t   cmd_now;
    drive_word_t want;

    int fail_count   = 0;
    int stuck_cycles = 0;
    int cmd_gap      = 0;
    int res_stall    = 0;
    bit cmd_gaps_on  = 1'b0;
    bit res_stalls_on = 1'b0;

    // controller settings as the block should hold them
    logic [GAIN_W-1:0]   set_kp, set_ki, set_kd;
    logic [ICAP_W-1:0]   set_icap;
    logic [SLEW_W-1:0]   set_slew;
    logic [SETTLE_W-1:0] set_settle;

    // controller state as the block should hold it
    logic signed [TARGET_W-1:0] goal_pos;
    logic signed [ERR_W-1:0]    last_err, last_der;
    logic signed [SUM_W-1:0]    err_sum;
    logic [SLEW_W-1:0]          speed_cap;
    logic                       moving;
    logic [SETTLE_W-1:0]        settle_cnt;

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic void reset_controller();
        set_kp     = KP_RESET;
        set_ki     = KI_RESET;
        set_kd     = KD_RESET;
        set_icap   = ICAP_RESET;
        set_slew   = SLEW_RESET;
        set_settle = SETTLE_RESET;
        goal_pos   = '0;
        last_err   = '0;
        last_der   = '0;
        err_sum    = '0;
        speed_cap  = SPEED_START;
        moving     = 1'b1;
        settle_cnt = '0;
    endfunction

    // drive word for one command word, advancing the controller state
    function automatic drive_word_t predict_drive(cmd_word_t w);
        drive_word_t       res;
        logic signed [63:0] rpos, lpos, gx, err, der, tot, lim;
        logic signed [79:0] acc, cap80;
        int unsigned        new_cap;
        res.drive_pct = '0;
        res.done_res  = 1'b0;
        if (w.action == ACT_START) begin
            goal_pos   = w.target;
            settle_cnt = '0;
            return res;
        end
        // settled: answer done until the next start
        if (settle_cnt >= set_settle) begin
            res.done_res = 1'b1;
            return res;
        end
        if (moving)
            settle_cnt = '0;
        moving = !(last_der > -2 && last_der < 2);

        // errors in half-degree units
        rpos = w.right_pos;
        lpos = w.left_pos;
        gx   = goal_pos;
        err  = clamp64(2 * gx - (rpos - lpos), ERR_MIN, ERR_MAX);
        der  = clamp64(err - last_err, ERR_MIN, ERR_MAX);
        tot  = clamp64(err_sum + err, SUM_MIN, SUM_MAX);
        last_err = err[ERR_W-1:0];
        last_der = der[ERR_W-1:0];

        // exact sum of the three gain terms, floored by the q8.24 point and half-degree
        acc = 80'(err) * $signed({48'd0, set_kp})
            + 80'(tot) * $signed({48'd0, set_ki})
            + 80'(der) * $signed({48'd0, set_kd});
        acc = acc >>> 25;

        new_cap   = speed_cap + set_slew;
        speed_cap = (new_cap > SPEED_MAX) ? SPEED_MAX : new_cap[SLEW_W-1:0];

        lim     = {39'd0, set_icap, 1'b0};
        err_sum = (tot > lim) ? lim[SUM_W-1:0] : tot[SUM_W-1:0];

        cap80 = 80'(speed_cap);
        if (acc > cap80)
            acc = cap80;
        if (acc < DRIVE_MIN)
            acc = 80'(DRIVE_MIN);

        if (settle_cnt != '1)
            settle_cnt = settle_cnt + 1'b1;
        res.drive_pct = acc[DRIVE_W-1:0];
        return res;
    endfunction

    // stimulus builders
    function automatic void add_word(t_action act, int tgt, int lft, int rgt);
        cmd_word_t w;
        w.action    = act;
        w.target    = 16'(tgt);
        w.left_pos  = POS_WIDTH'(lft);
        w.right_pos = POS_WIDTH'(rgt);
        cmd_backlog.push_back(w);
    endfunction

    function automatic void add_start(int tgt);
        add_word(ACT_START, tgt, $urandom(), $urandom());
    endfunction

    // tick whose position (right minus left) equals diff, at a random offset
    function automatic void add_tick(int diff);
        int lft;
        lft = int'($urandom_range(0, 1 << 23)) - (1 << 22);
        add_word(ACT_TICK, $urandom(), lft, lft + diff);
    endfunction

    // start, approach the target, then hold still, long enough to settle unless settle ticks exceed 24
    function automatic void queue_move();
        int                         tgt, diff, steps, hold, i;
        logic signed [TARGET_W-1:0] wide;
        wide = TARGET_W'($urandom());
        tgt  = ($urandom_range(0, 7) == 0) ? int'(wide) : int'($urandom_range(0, 4000)) - 2000;
        add_start(tgt);
        diff  = 2 * tgt + int'($urandom_range(0, 8000)) - 4000;
        steps = $urandom_range(1, 6);
        for (i = steps; i > 0; i--) begin
            diff += (2 * tgt - diff) / i;
            add_tick(diff);
        end
        hold = (set_settle > 24) ? 26 : int'(set_settle) + int'($urandom_range(2, 5));
        // broken move: cut the hold short
        if ($urandom_range(0, 5) == 0)
            hold = $urandom_range(0, hold);
        for (i = 0; i < hold; i++)
            add_tick(($urandom_range(0, 5) == 0) ? diff + 1 : diff);
    endfunction

    function automatic void queue_random(int n);
        int base;
        base = cmd_backlog.size();
        while (cmd_backlog.size() - base < n) begin
            if ($urandom_range(0, 5) == 0)
                add_word(t_action'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
            else
                queue_move();
        end
    endfunction

    function automatic logic [31:0] gain_pick(int unsigned typical);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom();
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    // register write, taken at the following rising edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_KP_GAIN:      set_kp     = data[GAIN_W-1:0];
            CFG_KI_GAIN:      set_ki     = data[GAIN_W-1:0];
            CFG_KD_GAIN:      set_kd     = data[GAIN_W-1:0];
            CFG_INTEGRAL_CAP: set_icap   = data[ICAP_W-1:0];
            CFG_SLEW_STEP:    set_slew   = data[SLEW_W-1:0];
            CFG_SETTLE_TICKS: set_settle = data[SETTLE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic randomize_settings();
        logic [CFG_DATA_W-1:0] data;
        write_reg(CFG_KP_GAIN, gain_pick(1 << 23));
        write_reg(CFG_KI_GAIN, gain_pick(1 << 14));
        write_reg(CFG_KD_GAIN, gain_pick(1 << 22));
        data = $urandom();
        case ($urandom_range(0, 4))
            0: data[ICAP_W-1:0] = '0;
            1: data[ICAP_W-1:0] = '1;
            2: ;
            default: data[ICAP_W-1:0] = ICAP_W'($urandom_range(0, 20000));
        endcase
        write_reg(CFG_INTEGRAL_CAP, data);
        data = $urandom();
        case ($urandom_range(0, 5))
            0: data[SLEW_W-1:0] = '0;
            1: data[SLEW_W-1:0] = SPEED_MAX;
            2: data[SLEW_W-1:0] = '1;
            default: data[SLEW_W-1:0] = SLEW_W'($urandom_range(1, 20));
        endcase
        write_reg(CFG_SLEW_STEP, data);
        data = $urandom();
        case ($urandom_range(0, 9))
            0: data[SETTLE_W-1:0] = '0;
            1: data[SETTLE_W-1:0] = '1;
            default: data[SETTLE_W-1:0] = SETTLE_W'($urandom_range(1, 10));
        endcase
        write_reg(CFG_SETTLE_TICKS, data);
        if ($urandom_range(0, 1) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
    endtask

    // wait until every queued word went through and every drive word came back
    task automatic drain();
        while (cmd_backlog.size() != 0 || cmd_bus.valid || drive_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // command driver: offers queued words, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            cmd_gap = 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready)
                drive_expected.push_back(predict_drive(cmd_now));
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (cmd_gap > 0) begin
                    cmd_gap--;
                    cmd_bus.valid <= 1'b0;
                end else if (cmd_gaps_on && $urandom_range(0, 7) == 0) begin
                    cmd_gap = $urandom_range(0, 4);
                    cmd_bus.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cmd_now = cmd_backlog.pop_front();
                    cmd_bus.valid     <= 1'b1;
                    cmd_bus.action    <= cmd_now.action;
                    cmd_bus.target    <= cmd_now.target;
                    cmd_bus.left_pos  <= cmd_now.left_pos;
                    cmd_bus.right_pos <= cmd_now.right_pos;
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random stalls, checks each drive word against the oldest expected
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            res_stall = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (drive_expected.size() == 0) begin
                    $error("unexpected drive word: drive_pct %0d done_res %0b",
                           res_bus.drive_pct, res_bus.done_res);
                    fail_count++;
                end else begin
                    want = drive_expected.pop_front();
                    if (res_bus.drive_pct !== want.drive_pct) begin
                        $error("drive_pct: expected %0d, got %0d",
                               want.drive_pct, res_bus.drive_pct);
                        fail_count++;
                    end
                    if (res_bus.done_res !== want.done_res) begin
                        $error("done_res: expected %0b, got %0b",
                               want.done_res, res_bus.done_res);
                        fail_count++;
                    end
                end
            end
            if (res_stall > 0) begin
                res_stall--;
                res_bus.ready <= 1'b0;
            end else if (res_stalls_on && $urandom_range(0, 7) == 0) begin
                res_stall = $urandom_range(0, 4);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // count cycles with work outstanding but no word moving
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)
                || (cmd_backlog.size() == 0 && !cmd_bus.valid && drive_expected.size() == 0))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // main sequence
    initial begin
        int phase;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.action    = ACT_TICK;
        cmd_bus.target    = '0;
        cmd_bus.left_pos  = '0;
        cmd_bus.right_pos = '0;
        res_bus.ready     = 1'b0;
        reset_controller();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: tick before any start, extreme positions and targets
        cmd_gaps_on   = 1'b1;
        res_stalls_on = 1'b1;
        add_word(ACT_TICK, 0, 0, 0);
        add_start(0);
        add_word(ACT_TICK, 0, -(1 << (POS_WIDTH - 1)), (1 << (POS_WIDTH - 1)) - 1);
        add_word(ACT_TICK, -1, (1 << (POS_WIDTH - 1)) - 1, -(1 << (POS_WIDTH - 1)));
        add_start(32767);
        add_word(ACT_TICK, 0, 0, 0);
        add_word(ACT_TICK, 0, 0, 65534);
        add_word(ACT_TICK, 0, 0, 65534);
        add_start(-32768);
        add_word(ACT_TICK, 0, 65535, -1);
        add_word(ACT_TICK, 0, 65535, -1);
        add_word(ACT_TICK, 0, (1 << (POS_WIDTH - 1)) - 1, -(1 << (POS_WIDTH - 1)));
        drain();

        // zero settle time answers done at once; full gains, zero cap, step above 100
        write_reg(CFG_SETTLE_TICKS, 32'hFFFF_0000);
        write_reg(CFG_SLEW_STEP, '1);
        write_reg(CFG_KP_GAIN, '1);
        write_reg(CFG_KI_GAIN, '1);
        write_reg(CFG_KD_GAIN, '1);
        write_reg(CFG_INTEGRAL_CAP, 32'hFF00_0000);
        write_reg(CFG_SPARE_LO, $urandom());
        write_reg(CFG_SPARE_HI, $urandom());
        add_word(ACT_TICK, 0, 0, 0);
        add_word(ACT_TICK, 0, 0, 0);
        add_start(100);
        add_word(ACT_TICK, 0, 0, 0);
        drain();

        // one-tick settle, zero gains: done comes and stays until a start
        write_reg(CFG_SETTLE_TICKS, 32'd1);
        write_reg(CFG_KP_GAIN, '0);
        write_reg(CFG_KI_GAIN, '0);
        write_reg(CFG_KD_GAIN, '0);
        write_reg(CFG_INTEGRAL_CAP, 32'h00FF_FFFF);
        add_start(-5);
        add_word(ACT_TICK, 0, 3, 3);
        add_word(ACT_TICK, 0, 3, 3);
        add_word(ACT_TICK, 0, 3, 3);
        add_start(7);
        add_word(ACT_TICK, 0, 0, 14);
        drain();

        // random settings per phase, moves with random content plus noise
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            randomize_settings();
            cmd_gaps_on   = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            res_stalls_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            queue_random(PHASE_WORDS);
            drain();
        end

        if (fail_count == 0 && drive_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
